@@ rtl/tmcvg_pkg.sv @@
package tmcvg_pkg;

    // Glyph ROM is fixed at 4 KiB: 256 codes x 8 lines x 2 halves.
    localparam int GLYPH_ROM_DEPTH = 4096;
    localparam int GLYPH_AW        = 12;

    localparam logic [4:0] FG_INDEX = 5'd16;
    localparam logic [4:0] MONO_BG  = 5'd17;
    localparam logic [4:0] AUTO_BG  = 5'd4;

    localparam logic [3:0] CC_RESET = 4'd2;

    // colour control bits
    localparam int CC_VRAM_LOCK = 0;
    localparam int CC_CRAM_LOCK = 1;
    localparam int CC_COLOUR_EN = 2;
    localparam int CC_AUTO      = 3;

    // configuration register indexes
    localparam logic [1:0] CFG_COLOUR_SW = 2'd0;
    localparam logic [1:0] CFG_PROG_SW   = 2'd1;
    localparam logic [1:0] CFG_HALF_W    = 2'd2;

    typedef enum logic [2:0] {
        K_VWRITE  = 3'd0,
        K_VREAD   = 3'd1,
        K_CCWRITE = 3'd2,
        K_GLOAD   = 3'd3,
        K_RENDER  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VREAD,
        ST_CELL,
        ST_GLYPH
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] address;
        logic [7:0]  write_data;
        logic [3:0]  char_row;
        logic [3:0]  scan_line;
        logic [5:0]  column;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [4:0] pixel_0;
        logic [4:0] pixel_1;
        logic [4:0] pixel_2;
        logic [4:0] pixel_3;
        logic [4:0] pixel_4;
        logic [4:0] pixel_5;
        logic [4:0] pixel_6;
        logic [4:0] pixel_7;
    } t_out_item;

endpackage

@@ rtl/tmcvg_ram.sv @@
module tmcvg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tmcvg_pix.sv @@
module tmcvg_pix (
    input  logic [7:0]           i_glyph,
    input  logic [4:0]           i_bg,
    output tmcvg_pkg::t_out_item o_item
);
    import tmcvg_pkg::*;

    logic [4:0] pix [8];

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            pix[j] = i_glyph[j] ? FG_INDEX : i_bg;
        end
    end

    assign o_item = '{read_data: 8'd0,
                      pixel_0: pix[0], pixel_1: pix[1], pixel_2: pix[2], pixel_3: pix[3],
                      pixel_4: pix[4], pixel_5: pix[5], pixel_6: pix[6], pixel_7: pix[7]};

endmodule

@@ rtl/text_mode_colour_video_generator_unit.sv @@
// Results: writes take effect at the accepting edge; a video read result is registered
//   from ST_VREAD, a render result from ST_GLYPH after ST_CELL, each when output is free.
// Throughput: writes 1 item/cycle; a read or render holds ready low until its result is
//   loaded, a render walking the chained video RAM -> glyph ROM reads, one port each.
// Reset: synchronous, active low; colour control goes to 2, switches to 0, then a
//   sweep over every address zeroes video and colour RAM before input is taken.
module text_mode_colour_video_generator_unit #(
    parameter int VIDEO_RAM_DEPTH = 1024,
    parameter int TEXT_ROWS       = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tmcvg_pkg::t_in_item  i_in,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tmcvg_pkg::t_out_item o_out,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [0:0]           i_cfg_data
);
    import tmcvg_pkg::*;

    localparam int VA_W      = $clog2(VIDEO_RAM_DEPTH);
    localparam int WRAP_MAX  = 4096 / VIDEO_RAM_DEPTH;
    localparam int ROW_MAX   = 16 / TEXT_ROWS;

    // Reduce a 12-bit offset modulo the video RAM depth: pick the largest
    // constant multiple not above it (independent compares).
    function automatic logic [VA_W-1:0] wrap_video(input logic [11:0] a);
        logic [11:0] r;
        r = a;
        for (int k = 1; k <= WRAP_MAX; k++) begin
            if (int'(a) >= k * VIDEO_RAM_DEPTH) begin
                r = 12'(int'(a) - k * VIDEO_RAM_DEPTH);
            end
        end
        return r[VA_W-1:0];
    endfunction

    function automatic logic [3:0] wrap_row(input logic [3:0] a);
        logic [3:0] r;
        r = a;
        for (int k = 1; k <= ROW_MAX; k++) begin
            if (int'(a) >= k * TEXT_ROWS) begin
                r = 4'(int'(a) - k * TEXT_ROWS);
            end
        end
        return r;
    endfunction

    // ---------------- state ----------------
    t_state     r_state, n_state;
    logic [VA_W-1:0] r_clr_addr;
    logic [3:0] r_cc;
    logic       r_sw_colour, r_sw_prog, r_half;
    logic [3:0] r_scan;          // scanline of the render in flight
    logic [4:0] r_bg, n_bg;      // background index of the render in flight
    logic       r_out_valid;
    t_out_item  r_out;

    // ---------------- memory ports ----------------
    logic              vram_we, vram_re, cram_we, cram_re, grom_we, grom_re;
    logic [VA_W-1:0]   v_waddr, v_raddr;
    logic [7:0]        v_wdata;
    logic [7:0]        vram_q, cram_q, grom_q;
    logic [GLYPH_AW-1:0] g_raddr;

    // ---------------- handshake helpers ----------------
    logic       in_xfer;
    logic       out_free;
    logic       out_load;
    t_out_item  out_next;
    t_out_item  pix_item;

    logic [5:0]      col_term;
    logic [VA_W-1:0] cell_addr;
    logic [VA_W-1:0] cpu_addr;
    logic            col_en, auto_en;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Cell position: 64 cells per line; half width doubles the column and drops bit 5.
    assign col_term  = r_half ? {i_in.column[4:0], 1'b0} : i_in.column;
    assign cell_addr = wrap_video({2'b00, wrap_row(i_in.char_row), col_term});
    assign cpu_addr  = wrap_video(i_in.address);

    assign col_en  = r_cc[CC_COLOUR_EN] && r_sw_colour;
    assign auto_en = r_cc[CC_AUTO] || !r_sw_prog;

    // Glyph address: scanline bit 3 picks the upper ROM half.
    assign g_raddr = {r_scan[3], vram_q, r_scan[2:0]};

    // ---------------- sequencer ----------------
    always_comb begin
        n_state  = r_state;
        n_bg     = r_bg;
        vram_we  = 1'b0;
        cram_we  = 1'b0;
        grom_we  = 1'b0;
        vram_re  = 1'b0;
        cram_re  = 1'b0;
        grom_re  = 1'b0;
        v_waddr  = cpu_addr;
        v_wdata  = i_in.write_data;
        v_raddr  = cpu_addr;
        out_load = 1'b0;
        out_next = pix_item;

        unique case (r_state)
            ST_CLEAR: begin
                vram_we = 1'b1;
                cram_we = 1'b1;
                v_waddr = r_clr_addr;
                v_wdata = 8'd0;
                if (r_clr_addr == VA_W'(VIDEO_RAM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    case (i_in.kind)
                        K_VWRITE: begin
                            vram_we = !r_cc[CC_VRAM_LOCK];
                            cram_we = !r_cc[CC_CRAM_LOCK];
                        end
                        K_VREAD: begin
                            vram_re = 1'b1;
                            n_state = ST_VREAD;
                        end
                        K_GLOAD: begin
                            grom_we = 1'b1;
                        end
                        K_RENDER: begin
                            vram_re = 1'b1;
                            cram_re = 1'b1;
                            v_raddr = cell_addr;
                            n_state = ST_CELL;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_VREAD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_next = '0;
                    out_next.read_data = vram_q;
                    n_state = ST_IDLE;
                end
            end
            ST_CELL: begin
                grom_re = 1'b1;
                if (!col_en) begin
                    n_bg = MONO_BG;
                end else if (auto_en) begin
                    n_bg = AUTO_BG;
                end else begin
                    n_bg = {1'b0, cram_q[3:0]};
                end
                n_state = ST_GLYPH;
            end
            ST_GLYPH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_cc        <= CC_RESET;
            r_sw_colour <= 1'b0;
            r_sw_prog   <= 1'b0;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + VA_W'(1);
            end
            if (in_xfer && i_in.kind == K_CCWRITE) begin
                r_cc <= i_in.write_data[3:0];
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_COLOUR_SW: r_sw_colour <= i_cfg_data[0];
                    CFG_PROG_SW:   r_sw_prog   <= i_cfg_data[0];
                    CFG_HALF_W:    r_half      <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bg <= n_bg;
        if (in_xfer) begin
            r_scan <= i_in.scan_line;
        end
        if (out_load) begin
            r_out <= out_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------- memories ----------------
    tmcvg_ram #(.WIDTH(8), .DEPTH(VIDEO_RAM_DEPTH)) u_vram (
        .i_clk   (i_clk),
        .i_we    (vram_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_re    (vram_re),
        .i_raddr (v_raddr),
        .o_rdata (vram_q)
    );

    tmcvg_ram #(.WIDTH(8), .DEPTH(VIDEO_RAM_DEPTH)) u_cram (
        .i_clk   (i_clk),
        .i_we    (cram_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_re    (cram_re),
        .i_raddr (v_raddr),
        .o_rdata (cram_q)
    );

    tmcvg_ram #(.WIDTH(8), .DEPTH(GLYPH_ROM_DEPTH)) u_grom (
        .i_clk   (i_clk),
        .i_we    (grom_we),
        .i_waddr (i_in.address),
        .i_wdata (i_in.write_data),
        .i_re    (grom_re),
        .i_raddr (g_raddr),
        .o_rdata (grom_q)
    );

    tmcvg_pix u_pix (
        .i_glyph (grom_q),
        .i_bg    (r_bg),
        .o_item  (pix_item)
    );

    // ---------------- checks ----------------
    a_render_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in.kind == K_RENDER) |=> (r_state == ST_CELL) ##1 (r_state == ST_GLYPH))
        else $error("render did not walk cell then glyph stage");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_VREAD || $past(r_state) == ST_GLYPH))
        else $error("result appeared outside a read or render");

    a_render_rd0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid) && $past(r_state) == ST_GLYPH) |-> (o_out.read_data == 8'd0))
        else $error("render result carries read data");

    a_vram_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_cc[CC_VRAM_LOCK]) |-> !vram_we)
        else $error("video RAM written while locked");

    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |=> !$past(in_xfer))
        else $error("item taken during clearing sweep");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import tmcvg_pkg::*;

    localparam int VRAM_DEPTH   = 1024;
    localparam int TEXT_ROWS    = 16;
    localparam int LINE_STRIDE  = 64;
    localparam int GROM_DEPTH   = GLYPH_ROM_DEPTH;
    localparam int PHASE_ITEMS  = 190;
    localparam int CODE_POOL    = 8;    // small set of codes so renders reuse loaded glyphs
    localparam int SETTLE_TICKS = 10;   // covers a render in flight, plus margin
    localparam int CYCLE_LIMIT  = 1000000;

    // kinds the block has no name for; they must be ignored
    localparam logic [2:0] K_SPARE_5 = 3'd5;
    localparam logic [2:0] K_SPARE_6 = 3'd6;
    localparam logic [2:0] K_SPARE_7 = 3'd7;

    typedef struct packed {
        t_in_item  stim;
        logic      typed;   // 1: want is written out in the table
        t_out_item want;
    } t_row;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    t_in_item   in_item     = '0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    t_out_item  out_item;
    logic       cfg_we      = 1'b0;
    logic [1:0] cfg_index   = CFG_COLOUR_SW;
    logic [0:0] cfg_data    = 1'b0;

    // Shadow copy of the display state, advanced once per accepted transfer.
    logic [7:0] vram_m      [VRAM_DEPTH];
    logic [7:0] cram_m      [VRAM_DEPTH];
    logic [7:0] grom_m      [GROM_DEPTH];
    logic       grom_loaded [GROM_DEPTH];
    logic [3:0] cc_m;
    logic       sw_colour;
    logic       sw_prog;
    logic       half_line;

    t_out_item  scanout_q [$];   // results still owed by the block, oldest first
    t_row       directed_q [$];

    int         mismatches  = 0;
    int         cycles      = 0;
    int         hold_left   = 0;
    logic       steady_flow = 1'b0;  // 1: no gaps on either side

    // Switch settings per phase: bit 0 colour, bit 1 programmable, bit 2 half width.
    // All-on and all-off come first; every combination is visited.
    logic [2:0] switch_plan [8] = '{3'd7, 3'd0, 3'd5, 3'd2, 3'd6, 3'd1, 3'd3, 3'd4};

    text_mode_colour_video_generator_unit #(
        .VIDEO_RAM_DEPTH (VRAM_DEPTH),
        .TEXT_ROWS       (TEXT_ROWS)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Display model
    // ---------------------------------------------------------------

    // Eight pixels of one scanline: set glyph bits are foreground.
    function automatic t_out_item paint(input logic [7:0] gfx, input logic [4:0] bg);
        logic [39:0] px;
        for (int k = 0; k < 8; k++) begin
            px[39 - 5 * k -: 5] = gfx[k] ? FG_INDEX : bg;
        end
        return {8'h00, px};
    endfunction

    // Video RAM offset of the cell a render points at; half width shows even cells only.
    function automatic int cell_of(input t_in_item it);
        int c;
        c = half_line ? 2 * int'(it.column[4:0]) : int'(it.column);
        return ((int'(it.char_row) % TEXT_ROWS) * LINE_STRIDE + c) % VRAM_DEPTH;
    endfunction

    // Scanlines 8..15 live in the upper half of the glyph ROM.
    function automatic logic [11:0] glyph_addr_of(input t_in_item it);
        logic [7:0] code;
        code = vram_m[cell_of(it)];
        return {it.scan_line[3], code, it.scan_line[2:0]};
    endfunction

    task automatic display_step(input t_in_item it, output logic has, output t_out_item res);
        int         va;
        int         cell_idx;
        logic       col_en;
        logic       auto_en;
        logic [4:0] bg;
        has = 1'b0;
        res = '0;
        va  = int'(it.address) % VRAM_DEPTH;
        case (it.kind)
            K_VWRITE: begin
                if (!cc_m[CC_VRAM_LOCK]) vram_m[va] = it.write_data;
                if (!cc_m[CC_CRAM_LOCK]) cram_m[va] = it.write_data;
            end
            K_VREAD: begin
                has           = 1'b1;
                res.read_data = vram_m[va];
            end
            K_CCWRITE: cc_m = it.write_data[3:0];
            K_GLOAD: begin
                grom_m[it.address]      = it.write_data;
                grom_loaded[it.address] = 1'b1;
            end
            K_RENDER: begin
                cell_idx = cell_of(it);
                col_en   = cc_m[CC_COLOUR_EN] && sw_colour;
                auto_en  = cc_m[CC_AUTO] || !sw_prog;
                if (col_en && auto_en) begin
                    bg = AUTO_BG;
                end else if (col_en) begin
                    bg = {1'b0, cram_m[cell_idx][3:0]};
                end else begin
                    bg = MONO_BG;
                end
                res = paint(grom_m[glyph_addr_of(it)], bg);
                has = 1'b1;
            end
            default: ;  // spare kinds do nothing
        endcase
    endtask

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // Offer one item, hold it until the transfer, then book what it should produce.
    task automatic send_item(input t_in_item it, input logic typed, input t_out_item want);
        int        gap;
        logic      has;
        t_out_item res;
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        display_step(it, has, res);
        if (has) scanout_q.push_back(typed ? want : res);
    endtask

    function automatic t_in_item mk(input logic [2:0] kind, input logic [11:0] addr,
                                    input logic [7:0] data, input logic [3:0] row,
                                    input logic [3:0] scan, input logic [5:0] col);
        t_in_item it;
        it.kind       = kind;
        it.address    = addr;
        it.write_data = data;
        it.char_row   = row;
        it.scan_line  = scan;
        it.column     = col;
        return it;
    endfunction

    task automatic tab(input t_in_item it, input logic typed, input t_out_item want);
        directed_q.push_back('{stim: it, typed: typed, want: want});
    endtask

    // One random item. Renders are kept legal: if the glyph line they would fetch
    // was never loaded, a load of that line goes in first.
    task automatic random_item(inout int made);
        logic [63:0] r;
        t_in_item    it;
        t_in_item    ld;
        int          w;
        logic [11:0] ga;
        r  = {$urandom, $urandom};
        it = r[36:0];
        w  = $urandom_range(0, 99);
        if (w < 36) begin
            it.kind = K_RENDER;
            ga      = glyph_addr_of(it);
            if (!grom_loaded[ga]) begin
                r          = {$urandom, $urandom};
                ld         = r[36:0];
                ld.kind    = K_GLOAD;
                ld.address = ga;
                send_item(ld, 1'b0, '0);
                made++;
            end
        end else if (w < 60) begin
            it.kind = K_VWRITE;
            if (w < 48) it.write_data = 8'($urandom_range(0, CODE_POOL - 1));
        end else if (w < 70) begin
            it.kind = K_VREAD;
        end else if (w < 78) begin
            it.kind = K_CCWRITE;
        end else if (w < 96) begin
            it.kind = K_GLOAD;
            if (w < 90) it.address[10:3] = 8'($urandom_range(0, CODE_POOL - 1));
        end else begin
            // ignored kinds: no effect, not counted
            case ($urandom_range(0, 2))
                0: it.kind = K_SPARE_5;
                1: it.kind = K_SPARE_6;
                default: it.kind = K_SPARE_7;
            endcase
            made--;
        end
        send_item(it, 1'b0, '0);
        made++;
    endtask

    // ---------------------------------------------------------------
    // Output side: random back-pressure and the scoreboard
    // ---------------------------------------------------------------

    task automatic check_result(input t_out_item got);
        t_out_item   want;
        logic [39:0] pw;
        logic [39:0] pg;
        if (scanout_q.size() == 0) begin
            $display("%0t ns: result with nothing awaited, got %h", $time, got);
            mismatches++;
            return;
        end
        want = scanout_q.pop_front();
        if (got.read_data !== want.read_data) begin
            $display("%0t ns: read_data expected %0d got %0d",
                     $time, want.read_data, got.read_data);
            mismatches++;
        end
        pw = want[39:0];
        pg = got[39:0];
        for (int k = 0; k < 8; k++) begin
            if (pg[39 - 5 * k -: 5] !== pw[39 - 5 * k -: 5]) begin
                $display("%0t ns: pixel_%0d expected %0d got %0d",
                         $time, k, pw[39 - 5 * k -: 5], pg[39 - 5 * k -: 5]);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk) begin : result_side
        int r;
        if (rst_n && out_valid && out_ready) check_result(out_item);
        // ready: mostly high, short stalls, a few long ones
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (steady_flow) begin
            out_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                out_ready <= 1'b1;
            end else if (r < 97) begin
                out_ready <= 1'b0;
                hold_left <= $urandom_range(0, 2);
            end else begin
                out_ready <= 1'b0;
                hold_left <= $urandom_range(10, 30);
            end
        end
    end

    // Watchdog: covers the clear sweep after reset and the slowest legal run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial begin
        int   made;
        logic [2:0] plan;

        for (int a = 0; a < VRAM_DEPTH; a++) begin
            vram_m[a] = 8'h00;
            cram_m[a] = 8'h00;
        end
        for (int a = 0; a < GROM_DEPTH; a++) begin
            grom_m[a]      = 8'h00;
            grom_loaded[a] = 1'b0;
        end
        cc_m      = CC_RESET;
        sw_colour = 1'b0;
        sw_prog   = 1'b0;
        half_line = 1'b0;

        // Directed table, run with switches at reset (monochrome, 64 columns).
        // RAMs read back zero after the clear sweep, including at the top address.
        tab(mk(K_VREAD,   12'h000, 8'h00, 4'h0, 4'h0, 6'h00), 1'b1, '0);
        tab(mk(K_VREAD,   12'hFFF, 8'h00, 4'h0, 4'h0, 6'h00), 1'b1, '0);
        // last cell, last code, last glyph line
        tab(mk(K_VWRITE,  12'hFFF, 8'hFF, 4'h0, 4'h0, 6'h00), 1'b0, '0);
        tab(mk(K_VREAD,   12'h3FF, 8'h00, 4'h0, 4'h0, 6'h00), 1'b1, {8'hFF, 40'h0});
        tab(mk(K_GLOAD,   12'hFFF, 8'hA5, 4'h0, 4'h0, 6'h00), 1'b0, '0);
        tab(mk(K_RENDER,  12'h000, 8'h00, 4'hF, 4'hF, 6'h3F), 1'b1, paint(8'hA5, MONO_BG));
        // first cell, code 0: empty then full glyph line
        tab(mk(K_GLOAD,   12'h000, 8'h00, 4'h0, 4'h0, 6'h00), 1'b0, '0);
        tab(mk(K_RENDER,  12'h000, 8'h00, 4'h0, 4'h0, 6'h00), 1'b1, paint(8'h00, MONO_BG));
        tab(mk(K_GLOAD,   12'h000, 8'hFF, 4'h0, 4'h0, 6'h00), 1'b0, '0);
        tab(mk(K_RENDER,  12'h000, 8'h00, 4'h0, 4'h0, 6'h00), 1'b1, paint(8'hFF, MONO_BG));
        // scanline 8 fetches from the upper ROM half
        tab(mk(K_GLOAD,   12'h800, 8'h5A, 4'h0, 4'h0, 6'h00), 1'b0, '0);
        tab(mk(K_RENDER,  12'h000, 8'h00, 4'h0, 4'h8, 6'h00), 1'b1, paint(8'h5A, MONO_BG));
        // control keeps the low nibble only: F1 locks video RAM, opens colour RAM
        tab(mk(K_CCWRITE, 12'h000, 8'hF1, 4'h0, 4'h0, 6'h00), 1'b0, '0);
        tab(mk(K_VWRITE,  12'h000, 8'h55, 4'h0, 4'h0, 6'h00), 1'b0, '0);
        tab(mk(K_VREAD,   12'h400, 8'h00, 4'h0, 4'h0, 6'h00), 1'b1, '0);
        // colour enable without the side switch stays monochrome
        tab(mk(K_CCWRITE, 12'h000, 8'h0C, 4'h0, 4'h0, 6'h00), 1'b0, '0);
        tab(mk(K_RENDER,  12'h000, 8'h00, 4'h0, 4'h0, 6'h00), 1'b1, paint(8'hFF, MONO_BG));
        // spare kinds with every field at its top value
        tab(mk(K_SPARE_5, 12'hFFF, 8'hFF, 4'hF, 4'hF, 6'h3F), 1'b0, '0);
        tab(mk(K_SPARE_6, 12'hFFF, 8'hFF, 4'hF, 4'hF, 6'h3F), 1'b0, '0);
        tab(mk(K_SPARE_7, 12'hFFF, 8'hFF, 4'hF, 4'hF, 6'h3F), 1'b0, '0);
        // row 3, column 1, code 1, scanline 3
        tab(mk(K_VWRITE,  12'h0C1, 8'h01, 4'h0, 4'h0, 6'h00), 1'b0, '0);
        tab(mk(K_GLOAD,   12'h00B, 8'h81, 4'h0, 4'h0, 6'h00), 1'b0, '0);
        tab(mk(K_RENDER,  12'h000, 8'h00, 4'h3, 4'h3, 6'h01), 1'b1, paint(8'h81, MONO_BG));
        tab(mk(K_VREAD,   12'h0C1, 8'h00, 4'h0, 4'h0, 6'h00), 1'b1, {8'h01, 40'h0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_q[i]) begin
            send_item(directed_q[i].stim, directed_q[i].typed, directed_q[i].want);
        end

        for (int p = 0; p < 8; p++) begin
            // Switches change only with the block idle: drain every result, then
            // give any trailing write time to finish.
            in_valid <= 1'b0;
            while (scanout_q.size() != 0) @(posedge clk);
            repeat (SETTLE_TICKS) @(posedge clk);

            plan = switch_plan[p];
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_COLOUR_SW;
            cfg_data  <= plan[0];
            @(posedge clk);
            cfg_index <= CFG_PROG_SW;
            cfg_data  <= plan[1];
            @(posedge clk);
            cfg_index <= CFG_HALF_W;
            cfg_data  <= plan[2];
            @(posedge clk);
            cfg_we    <= 1'b0;
            sw_colour = plan[0];
            sw_prog   = plan[1];
            half_line = plan[2];

            // even phases open with a gap-free burst
            steady_flow <= (p % 2 == 0);
            made = 0;
            while (made < PHASE_ITEMS) begin
                if (made == 40) steady_flow <= 1'b0;
                random_item(made);
            end
            steady_flow <= 1'b0;
        end

        in_valid <= 1'b0;
        while (scanout_q.size() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        if (mismatches == 0 && scanout_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
